// ===== sv/ipv4_header_generator_assert.svh =====
// Assertion macros used by the bound checker of the header generator.
`ifndef IPV4_HEADER_GENERATOR_ASSERT_SVH
`define IPV4_HEADER_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IPV4HG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4 header generator: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define IPV4HG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4 header generator: next-cycle check failed");

`endif

// ===== sv/ipv4hg_pkg.sv =====
package ipv4hg_pkg;

    // Header geometry.
    localparam int unsigned NUM_WORDS = 10;
    localparam int unsigned WIDX_W    = 4;
    localparam logic [WIDX_W-1:0] LAST_INDEX = 4'd9;

    // Fixed header contents.
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  TTL_VALUE   = 8'd128;

    // Register map.
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_HOST    = 2'd0;
    localparam logic [1:0] REG_MASK    = 2'd1;
    localparam logic [1:0] REG_GATEWAY = 2'd2;

    localparam logic [31:0] HOST_RESET    = 32'hC0A8_02AA;
    localparam logic [31:0] MASK_RESET    = 32'hFFFF_FF00;
    localparam logic [31:0] GATEWAY_RESET = 32'hC0A8_0201;

    // Stream widths.
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 56;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gateway;
    } cfg_t;

    // One finished header with its next hop.
    typedef struct packed {
        logic [NUM_WORDS-1:0][15:0] words;
        logic [31:0]                hop;
    } hdr_t;

endpackage

// ===== sv/ipv4_header_generator.sv =====
// IPv4 header generator.
// Input stream: one beat per packet carrying destination address, protocol
// and total length. Output stream: ten beats per packet, one 16-bit header
// word each in network order, with the word index and the chosen next hop;
// tlast marks the tenth word. The APB port holds the host address, subnet
// mask and gateway; write it only while the block is idle.
// An accepted input beat is registered in the header builder; when the output
// side is free the header is then loaded into the serializer's hold register,
// from which its first word is presented.
// The ten output beats per packet set the packet rate; the
// next packet's header is built while the current one is still being sent,
// so its first word follows the previous last word in the next cycle.
// An input beat is held in its register while the serializer is busy, and
// s_axis_tready drops only while that register is full and cannot move on.
// When the receiver stalls, the current word is held steady until taken.
// Reset clears all valid flags and the identification counter and loads
// the register defaults.
module ipv4_header_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipv4hg_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Packet requests.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // destination_address[31:0], protocol_number[39:32], total_length[55:40]
    input  logic [ipv4hg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Header words.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // header_word[15:0], word_index[19:16], next_hop_address[51:20], zero[55:52]
    output logic [ipv4hg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);

    ipv4hg_pkg::cfg_t cfg;
    ipv4hg_pkg::hdr_t hdr;
    logic             hdr_valid;
    logic             hdr_ready;

    ipv4hg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipv4hg_hdr_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .cfg       (cfg),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr)
    );

    ipv4hg_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== sv/ipv4hg_cfg_regs.sv =====
module ipv4hg_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipv4hg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output ipv4hg_pkg::cfg_t              cfg
);

    logic [31:0] host_reg;
    logic [31:0] mask_reg;
    logic [31:0] gateway_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; addresses past the map are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg    <= ipv4hg_pkg::HOST_RESET;
            mask_reg    <= ipv4hg_pkg::MASK_RESET;
            gateway_reg <= ipv4hg_pkg::GATEWAY_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                ipv4hg_pkg::REG_HOST:    host_reg    <= pwdata;
                ipv4hg_pkg::REG_MASK:    mask_reg    <= pwdata;
                ipv4hg_pkg::REG_GATEWAY: gateway_reg <= pwdata;
                default:                 ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (paddr[3:2])
            ipv4hg_pkg::REG_HOST:    prdata = host_reg;
            ipv4hg_pkg::REG_MASK:    prdata = mask_reg;
            ipv4hg_pkg::REG_GATEWAY: prdata = gateway_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.host    = host_reg;
    assign cfg.mask    = mask_reg;
    assign cfg.gateway = gateway_reg;

endmodule

// ===== sv/ipv4hg_hdr_build.sv =====
module ipv4hg_hdr_build (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ipv4hg_pkg::IN_DATA_W-1:0] in_data,
    input  ipv4hg_pkg::cfg_t                 cfg,
    output logic                             hdr_valid,
    input  logic                             hdr_ready,
    output ipv4hg_pkg::hdr_t                 hdr
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] dest_reg;
    logic [7:0]  proto_reg;
    logic [15:0] len_reg;
    logic [15:0] id_reg;
    logic [15:0] id_next;
    logic        in_accept;
    logic        hdr_take;
    logic [19:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] checksum;

    assign hdr_valid = in_valid_reg;
    assign in_ready  = !in_valid_reg || hdr_ready;
    assign in_accept = in_valid && in_ready;
    assign hdr_take  = in_valid_reg && hdr_ready;

    assign in_valid_next = (in_valid_reg && !hdr_ready) || in_accept;
    assign id_next       = hdr_take ? id_reg + 16'd1 : id_reg;

    // Control state and the identification counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            id_reg       <= 16'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            id_reg       <= id_next;
        end
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dest_reg  <= in_data[31:0];
            proto_reg <= in_data[39:32];
            len_reg   <= in_data[55:40];
        end
    end

    // One's complement sum of the nine non-checksum words, folded twice.
    assign sum = 20'(ipv4hg_pkg::VER_IHL_TOS) + 20'(len_reg) + 20'(id_reg)
               + 20'(ipv4hg_pkg::FLAGS_DF) + 20'({ipv4hg_pkg::TTL_VALUE, proto_reg})
               + 20'(cfg.host[31:16]) + 20'(cfg.host[15:0])
               + 20'(dest_reg[31:16]) + 20'(dest_reg[15:0]);
    assign fold1    = 17'(sum[15:0]) + 17'(sum[19:16]);
    assign fold2    = fold1[15:0] + 16'(fold1[16]);
    assign checksum = ~fold2;

    // Header assembly and next-hop choice.
    always_comb
    begin
        hdr.words[0] = ipv4hg_pkg::VER_IHL_TOS;
        hdr.words[1] = len_reg;
        hdr.words[2] = id_reg;
        hdr.words[3] = ipv4hg_pkg::FLAGS_DF;
        hdr.words[4] = {ipv4hg_pkg::TTL_VALUE, proto_reg};
        hdr.words[5] = checksum;
        hdr.words[6] = cfg.host[31:16];
        hdr.words[7] = cfg.host[15:0];
        hdr.words[8] = dest_reg[31:16];
        hdr.words[9] = dest_reg[15:0];
        if ((dest_reg & cfg.mask) == (cfg.gateway & cfg.mask))
        begin
            hdr.hop = dest_reg;
        end
        else
        begin
            hdr.hop = cfg.gateway;
        end
    end

endmodule

// ===== sv/ipv4hg_serializer.sv =====
module ipv4hg_serializer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hdr_valid,
    output logic                              hdr_ready,
    input  ipv4hg_pkg::hdr_t                  hdr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ipv4hg_pkg::OUT_DATA_W-1:0] out_data,
    output logic                              out_last
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [ipv4hg_pkg::WIDX_W-1:0] idx_reg;
    logic [ipv4hg_pkg::WIDX_W-1:0] idx_next;
    ipv4hg_pkg::hdr_t              hdr_reg;
    logic                          last;
    logic                          out_accept;
    logic                          load;

    assign last       = (idx_reg == ipv4hg_pkg::LAST_INDEX);
    assign out_accept = busy_reg && out_ready;
    assign hdr_ready  = !busy_reg || (out_ready && last);
    assign load       = hdr_valid && hdr_ready;

    // Word sequencing: a new header follows the last beat without a gap.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        priority if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_accept && last)
        begin
            busy_next = 1'b0;
        end
        else if (out_accept)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Header hold register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg <= hdr;
        end
    end

    assign out_valid = busy_reg;
    assign out_last  = last;
    assign out_data  = {4'd0, hdr_reg.hop, idx_reg, hdr_reg.words[idx_reg]};

endmodule

// ===== sv/ipv4hg_checker.sv =====
`include "ipv4_header_generator_assert.svh"

module ipv4hg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ipv4hg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);

    logic                          out_accept;
    logic [ipv4hg_pkg::WIDX_W-1:0] idx;

    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign idx        = m_axis_tdata[19:16];

    // A stalled beat stays presented and unchanged.
    `IPV4HG_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The last flag marks exactly the tenth word.
    `IPV4HG_ASSERT_SAME(a_last_index, m_axis_tvalid, m_axis_tlast == (idx == ipv4hg_pkg::LAST_INDEX))

    // Within a header the words come back to back, in order, with one next hop.
    `IPV4HG_ASSERT_NEXT(a_word_step, out_accept && !m_axis_tlast, m_axis_tvalid && (idx == $past(idx) + 4'd1) && (m_axis_tdata[51:20] == $past(m_axis_tdata[51:20])))

    // A new header always starts at word zero.
    `IPV4HG_ASSERT_NEXT(a_new_header, out_accept && m_axis_tlast, !m_axis_tvalid || (idx == 4'd0))

endmodule

bind ipv4_header_generator ipv4hg_checker u_ipv4hg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/ipv4_header_checker.sv =====
`default_nettype none

// Watches the configuration port and both streams of the header generator,
// builds the ten header beats for every accepted packet request and compares
// each delivered beat against the oldest outstanding one.
module ipv4_header_checker
    import ipv4hg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic [31:0]           prdata,
    input  wire logic                  pready,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tlast,
    output int                         fail_count,
    output int                         pending_beats,
    output int                         packets_seen,
    output int                         beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // One header word as it should leave the block.
    typedef struct packed {
        logic [15:0]       word;
        logic [WIDX_W-1:0] index;
        logic [31:0]       hop;
        logic              last;
    } header_beat_t;

    header_beat_t   header_beats_due[$];
    header_beat_t   due_beat;
    header_beat_t   seen_beat;
    cfg_t           reg_shadow;
    logic [15:0]    ident_count;
    hdr_t           built_header;
    logic [1:0]     reg_index;

    // One's complement sum of the ten words, carries folded back, inverted.
    function automatic logic [15:0] header_checksum(input logic [NUM_WORDS-1:0][15:0] w);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_WORDS; i++)
            acc = acc + {16'h0, w[i]};
        while (acc[31:16] != 16'h0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // Complete header and next hop for one packet request.
    function automatic hdr_t build_ipv4_header(input cfg_t cfg, input logic [31:0] dest,
                                               input logic [7:0] proto, input logic [15:0] len,
                                               input logic [15:0] ident);
        hdr_t h;
        h.words[0] = VER_IHL_TOS;
        h.words[1] = len;
        h.words[2] = ident;
        h.words[3] = FLAGS_DF;
        h.words[4] = {TTL_VALUE, proto};
        h.words[5] = 16'h0;
        h.words[6] = cfg.host[31:16];
        h.words[7] = cfg.host[15:0];
        h.words[8] = dest[31:16];
        h.words[9] = dest[15:0];
        h.words[5] = header_checksum(h.words);
        // Deliver directly inside the gateway's subnet, otherwise via the gateway.
        if ((dest & cfg.mask) == (cfg.gateway & cfg.mask))
            h.hop = dest;
        else
            h.hop = cfg.gateway;
        return h;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            reg_shadow.host    <= HOST_RESET;
            reg_shadow.mask    <= MASK_RESET;
            reg_shadow.gateway <= GATEWAY_RESET;
            ident_count        <= 16'h0;
            header_beats_due.delete();
            fail_count    = 0;
            pending_beats = 0;
            packets_seen  = 0;
            beats_checked = 0;
        end
        else begin
            reg_index = paddr[ADDR_W-1:2];

            // Register writes; an index past the gateway is ignored.
            if (psel && penable && pwrite && pready) begin
                case (reg_index)
                    REG_HOST:    reg_shadow.host    <= pwdata;
                    REG_MASK:    reg_shadow.mask    <= pwdata;
                    REG_GATEWAY: reg_shadow.gateway <= pwdata;
                    default:     ;
                endcase
            end

            // Register reads return the current setting.
            if (psel && penable && !pwrite && pready) begin
                case (reg_index)
                    REG_HOST:    report_field("host readback", reg_shadow.host, prdata);
                    REG_MASK:    report_field("mask readback", reg_shadow.mask, prdata);
                    REG_GATEWAY: report_field("gateway readback", reg_shadow.gateway, prdata);
                    default:     ;
                endcase
            end

            // Accepted request beat: queue all ten header beats.
            if (s_axis_tvalid && s_axis_tready) begin
                built_header = build_ipv4_header(reg_shadow, s_axis_tdata[31:0],
                                                 s_axis_tdata[39:32], s_axis_tdata[55:40],
                                                 ident_count);
                for (int i = 0; i < NUM_WORDS; i++) begin
                    due_beat.word  = built_header.words[i];
                    due_beat.index = WIDX_W'(i);
                    due_beat.hop   = built_header.hop;
                    due_beat.last  = (WIDX_W'(i) == LAST_INDEX);
                    header_beats_due.push_back(due_beat);
                end
                ident_count <= ident_count + 16'h1;
                packets_seen++;
            end

            // Delivered header beat: compare with the oldest outstanding one.
            if (m_axis_tvalid && m_axis_tready) begin
                seen_beat.word  = m_axis_tdata[15:0];
                seen_beat.index = m_axis_tdata[19:16];
                seen_beat.hop   = m_axis_tdata[51:20];
                seen_beat.last  = m_axis_tlast;
                if (header_beats_due.size() == 0) begin
                    $display("%0t: unexpected header beat, expected none, actual %h",
                             $time, seen_beat);
                    fail_count++;
                end
                else begin
                    due_beat = header_beats_due.pop_front();
                    report_field("header word", 32'(due_beat.word), 32'(seen_beat.word));
                    report_field("word index", 32'(due_beat.index), 32'(seen_beat.index));
                    report_field("next hop", due_beat.hop, seen_beat.hop);
                    report_field("last flag", 32'(due_beat.last), 32'(seen_beat.last));
                    beats_checked++;
                end
            end

            pending_beats = header_beats_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4hg_pkg::*;

    // Index that maps to no register; writes there must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ROUNDS = 8;
    localparam int ROUND_PACKETS = 58;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // destination_address[31:0], protocol_number[39:32], total_length[55:40]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // header_word[15:0], word_index[19:16], next_hop_address[51:20], zero[55:52]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int fail_count;
    int pending_beats;
    int packets_seen;
    int beats_checked;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          settings_used = 1;

    // Current setting, kept here only to aim destinations at the subnet.
    logic [31:0] cur_mask = MASK_RESET;
    logic [31:0] cur_gateway = GATEWAY_RESET;

    ipv4_header_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ipv4_header_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .packets_seen  (packets_seen),
        .beats_checked (beats_checked)
    );

    always #5 clk = ~clk;

    // Receiver backpressure, redrawn every cycle.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic set_traffic(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            default:
            begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    // APB access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_setting(input logic [31:0] host, input logic [31:0] mask,
                                input logic [31:0] gateway);
        apb_access(1'b1, REG_HOST, host);
        apb_access(1'b1, REG_MASK, mask);
        apb_access(1'b1, REG_GATEWAY, gateway);
        apb_access(1'b0, REG_HOST, '0);
        apb_access(1'b0, REG_MASK, '0);
        apb_access(1'b0, REG_GATEWAY, '0);
        cur_mask    = mask;
        cur_gateway = gateway;
        settings_used++;
    endtask

    // Presents one packet request and holds it until it is taken.
    task automatic send_request(input logic [31:0] dest, input logic [7:0] proto,
                                input logic [15:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, proto, dest};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [31:0] dest;
        logic [7:0]  proto;
        logic [15:0] len;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            dest = (cur_gateway & cur_mask) | ($urandom() & ~cur_mask);
        else if (pick < 85)
            dest = $urandom();
        else if (pick < 92)
            dest = cur_gateway;
        else if (pick < 96)
            dest = 32'h0;
        else
            dest = 32'hFFFF_FFFF;
        pick = $urandom_range(99);
        if (pick < 70)
            len = 16'($urandom_range(1500, 20));
        else if (pick < 85)
            len = 16'($urandom_range(65535, 1501));
        else if (pick < 95)
            len = 16'($urandom());
        else
            len = 16'($urandom_range(19, 0));
        proto = 8'($urandom());
        send_request(dest, proto, len);
    endtask

    // Lets the block finish every header before the next setting is loaded.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gateway;
        int unsigned prefix;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values read back.
        apb_access(1'b0, REG_HOST, '0);
        apb_access(1'b0, REG_MASK, '0);
        apb_access(1'b0, REG_GATEWAY, '0);

        // Default setting: on-subnet, off-subnet, field extremes, short lengths.
        set_traffic(0);
        send_request(32'hC0A8_0205, 8'd17, 16'd20);
        send_request(32'h0808_0808, 8'd6, 16'd1500);
        send_request(32'h0000_0000, 8'd0, 16'd0);
        send_request(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
        send_request(32'hC0A8_02FF, 8'd1, 16'd19);
        send_request(GATEWAY_RESET, 8'd17, 16'd21);
        send_request(32'hC0A8_0301, 8'd6, 16'd40);
        wait_idle();

        // A write to the unused index must leave the setting alone.
        apb_access(1'b1, REG_UNUSED, $urandom());
        apb_access(1'b0, REG_HOST, '0);
        apb_access(1'b0, REG_MASK, '0);
        apb_access(1'b0, REG_GATEWAY, '0);
        send_request(32'hC0A8_0277, 8'd17, 16'd576);
        wait_idle();

        // Empty mask: every destination counts as local.
        load_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 8'd255, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 8'd0, 16'd20);
        wait_idle();

        // Full mask: only the gateway itself counts as local.
        load_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 8'd6, 16'd1000);
        send_request(32'hFFFF_FFFE, 8'd17, 16'd20);
        wait_idle();

        // Random rounds, each with its own setting and one of four traffic patterns in turn.
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            prefix = $urandom_range(30, 8);
            if (r == 1)
                prefix = 0;
            else if (r == 2)
                prefix = 32;
            mask    = 32'(64'hFFFF_FFFF_0000_0000 >> prefix);
            gateway = $urandom();
            host    = (gateway & mask) | ($urandom() & ~mask);
            if (r == 5)
            begin
                host    = 32'h0;
                gateway = 32'hFFFF_FFFF;
            end
            load_setting(host, mask, gateway);
            set_traffic(r % 4);
            for (int i = 0; i < ROUND_PACKETS; i++)
                send_random_request();
            wait_idle();
        end

        repeat (20) @(negedge clk);
        $display("Covered %0d packet requests and %0d header beats over %0d register settings,",
                 packets_seen, beats_checked, settings_used);
        $display("with mask extremes, short lengths and idle/stall mixes on both streams.");
        if (fail_count == 0 && pending_beats == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
